// ===== rtl/core/ttpw_pkg.sv =====
package ttpw_pkg;

    // Field widths
    localparam int POS_W      = 10;
    localparam int SRC_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int LW_W       = 11;
    localparam int MODE_W     = 2;
    localparam int OFF_W      = 22;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 2;

    // Surface and palette limits
    localparam int MAX_WIDTH  = 1024;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);

    // Stream packing (fields from the lowest bit up, padded to bytes)
    localparam int IN_BITS    = 2 * POS_W + SRC_W + 4 * BYTE_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = OFF_W + DATA_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + POS_W;
    localparam int SRC_LSB    = Y_LSB + POS_W;
    localparam int IDX_LSB    = SRC_LSB + SRC_W;
    localparam int RED_LSB    = IDX_LSB + BYTE_W;
    localparam int GREEN_LSB  = RED_LSB + BYTE_W;
    localparam int BLUE_LSB   = GREEN_LSB + BYTE_W;

    // Tile geometry (bytes)
    localparam int HALF_OFFSET = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = CFG_IDX_W'(1);

    // Pixel modes
    localparam logic [MODE_W-1:0] MODE_PAL8   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_RGB565 = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_RGB    = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_ARGB   = MODE_W'(3);

    // Operation codes
    localparam logic OP_PAL_WRITE = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    localparam logic [LW_W-1:0]   LW_RESET   = LW_W'(640);
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_RGB565;

endpackage

// ===== rtl/core/tiled_texture_pixel_writer_unit.sv =====
// Tiled texture pixel writer.
// Input stream (s_*): s_tuser is the operation (palette write or pixel),
// s_tdata carries position, source bytes and palette entry fields.
// A palette write stores an RGB565 entry at its transfer and gives no result.
// A pixel gives one 16-bit write (palette and RGB565 modes) or two writes
// (RGB and ARGB modes, second one 32 bytes past the first) on m_*, with
// m_tlast marking the final write of the pixel.
// Config port (cfg_*): register 0 line width, register 1 pixel mode; always
// ready. The user must write it only while the block is idle; the block
// itself does not enforce this. A pixel's first write appears on m_tvalid
// after the work stage and the output register. Throughput: one pixel per
// cycle in the 16-bit modes while the receiver does not stall; in the 32-bit
// modes only as the second write of the last pixel enters the output register.
// Palette reads use a registered memory port read in the transfer cycle.
// Reset: line width 640, RGB565 mode, all palette entries read as zero
// (per-entry valid bits), pipeline empty. When the receiver stalls, the
// output register holds and the stall backs up to s_tready; one pixel
// can wait in the work stage behind a held result.
module tiled_texture_pixel_writer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, src_word, pal_index, red, green, blue, zero pad
    input  logic [ttpw_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                             s_tuser,
    // Output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // byte_offset, write_data, zero pad
    output logic [ttpw_pkg::OUT_TDATA_W-1:0] m_tdata,
    // last
    output logic                             m_tlast,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ttpw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttpw_pkg::LW_W-1:0]        cfg_data
);
    import ttpw_pkg::*;

    // Configuration registers
    logic [LW_W-1:0]   line_width_reg;
    logic [MODE_W-1:0] pixel_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LW_RESET;
            pixel_mode_reg <= MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_LINE_WIDTH)
            begin
                line_width_reg <= cfg_data;
            end
            else if (cfg_index == REG_PIXEL_MODE)
            begin
                pixel_mode_reg <= cfg_data[MODE_W-1:0];
            end
        end
    end

    // Input field unpacking
    logic [POS_W-1:0]  in_x;
    logic [POS_W-1:0]  in_y;
    logic [SRC_W-1:0]  in_src;
    logic [PAL_AW-1:0] in_idx;
    logic [BYTE_W-1:0] in_red;
    logic [BYTE_W-1:0] in_green;
    logic [BYTE_W-1:0] in_blue;
    logic [PAL_AW-1:0] rd_idx;
    logic [DATA_W-1:0] pal_entry;

    assign in_x     = s_tdata[X_LSB +: POS_W];
    assign in_y     = s_tdata[Y_LSB +: POS_W];
    assign in_src   = s_tdata[SRC_LSB +: SRC_W];
    assign in_idx   = s_tdata[IDX_LSB +: PAL_AW];
    assign in_red   = s_tdata[RED_LSB +: BYTE_W];
    assign in_green = s_tdata[GREEN_LSB +: BYTE_W];
    assign in_blue  = s_tdata[BLUE_LSB +: BYTE_W];
    assign rd_idx   = in_src[SRC_W-1 -: PAL_AW];

    assign pal_entry = {in_red[BYTE_W-1 -: 5], in_green[BYTE_W-1 -: 6],
                        in_blue[BYTE_W-1 -: 5]};

    // Handshake and stage control
    logic s_accept;
    logic pal_wr;
    logic px_in;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_phase_reg;
    logic s1_phase_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic s1_move;
    logic s1_last;
    logic s1_wide;

    assign s_accept = s_tvalid && s_tready;
    assign pal_wr   = s_accept && (s_tuser == OP_PAL_WRITE);
    assign px_in    = s_accept && (s_tuser == OP_PIXEL);
    assign s1_wide  = (pixel_mode_reg == MODE_RGB) || (pixel_mode_reg == MODE_ARGB);
    assign s1_last  = !s1_wide || s1_phase_reg;
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || (s1_move && s1_last);

    // Palette memory with per-entry valid bits
    logic [DATA_W-1:0]    pal_mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] pal_vld_reg;
    logic [DATA_W-1:0]    pal_rd_reg;
    logic                 pal_hit_reg;

    always_ff @(posedge clk)
    begin
        if (pal_wr)
        begin
            pal_mem[in_idx] <= pal_entry;
        end
        if (px_in)
        begin
            pal_rd_reg <= pal_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_vld_reg <= '0;
            pal_hit_reg <= 1'b0;
        end
        else
        begin
            if (pal_wr)
            begin
                pal_vld_reg[in_idx] <= 1'b1;
            end
            if (px_in)
            begin
                pal_hit_reg <= pal_vld_reg[rd_idx];
            end
        end
    end

    // Work stage registers
    logic [POS_W-1:0] s1_x_reg;
    logic [POS_W-1:0] s1_y_reg;
    logic [SRC_W-1:0] s1_src_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        if (s1_move)
        begin
            if (s1_last)
            begin
                s1_valid_next = 1'b0;
            end
            else
            begin
                s1_phase_next = 1'b1;
            end
        end
        if (px_in)
        begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_phase_reg <= s1_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (px_in)
        begin
            s1_x_reg   <= in_x;
            s1_y_reg   <= in_y;
            s1_src_reg <= in_src;
        end
    end

    // Tile offset: row of tiles, tile in row, pixel in tile, second half
    logic [LW_W-1:0]         w_eff;
    logic [POS_W-3+LW_W-1:0] row_prod;
    logic [OFF_W-1:0]        row_off;
    logic [OFF_W-1:0]        col_off;
    logic [OFF_W-1:0]        pix_off;
    logic [OFF_W-1:0]        half_off;
    logic [OFF_W-1:0]        s1_offset;

    assign w_eff    = (line_width_reg > LW_W'(MAX_WIDTH)) ? LW_W'(MAX_WIDTH)
                                                          : line_width_reg;
    assign row_prod = s1_y_reg[POS_W-1:2] * w_eff;
    assign row_off  = s1_wide ? (OFF_W'(row_prod) << 4) : (OFF_W'(row_prod) << 3);
    assign col_off  = s1_wide ? (OFF_W'(s1_x_reg[POS_W-1:2]) << 6)
                              : (OFF_W'(s1_x_reg[POS_W-1:2]) << 5);
    assign pix_off  = OFF_W'({s1_y_reg[1:0], s1_x_reg[1:0], 1'b0});
    assign half_off = s1_phase_reg ? OFF_W'(HALF_OFFSET) : '0;
    // Offsets fit the texture size, so the wrap is the field width
    assign s1_offset = row_off + col_off + pix_off + half_off;

    // Write data per mode and half
    logic [DATA_W-1:0] s1_data;

    always_comb
    begin
        unique case (pixel_mode_reg)
            MODE_PAL8:
            begin
                s1_data = pal_hit_reg ? pal_rd_reg : '0;
            end
            MODE_RGB565:
            begin
                s1_data = s1_src_reg[SRC_W-1 -: DATA_W];
            end
            MODE_RGB:
            begin
                s1_data = s1_phase_reg ? s1_src_reg[23:8]
                                       : {8'hFF, s1_src_reg[SRC_W-1 -: BYTE_W]};
            end
            default:
            begin
                s1_data = s1_phase_reg ? s1_src_reg[DATA_W-1:0]
                                       : s1_src_reg[SRC_W-1 -: DATA_W];
            end
        endcase
    end

    // Output register
    logic [OFF_W-1:0]  out_offset_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_offset_reg <= s1_offset;
            out_data_reg   <= s1_data;
            out_last_reg   <= s1_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), out_data_reg, out_offset_reg};

`ifndef ASSERT_OFF
    // The second half is only ever worked on in the two-write modes
    a_phase_wide: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_phase_reg |-> s1_wide)
        else $error("second write pending in a single-write mode");

    // A first write is always followed directly by its final write
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("first write not followed by its final write");

    // The second write sits 32 bytes past the first
    a_pair_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tdata[OFF_W-1:0] == $past(m_tdata[OFF_W-1:0]) + OFF_W'(HALF_OFFSET))
        else $error("second write offset mismatch");
`endif

endmodule

// ===== tb/sv/tiled_texture_pixel_writer_unit_test.sv =====
`timescale 1ns / 100ps

module tiled_texture_pixel_writer_unit_test;
    import ttpw_pkg::*;

    localparam longint TEX_BYTES    = 4194304;
    localparam int     IDLE_CYCLES  = 8;
    localparam int     DRAIN_LIMIT  = 2000;
    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     PHASES       = 8;
    localparam int     PHASE_PIXELS = 160;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // One input item, unpacked
    typedef struct {
        logic              op;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SRC_W-1:0]  src;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } texel_item_t;

    // One two-byte texture write
    typedef struct {
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] data;
        logic              last;
    } texel_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LW_W-1:0]        cfg_data;

    // Predictor state
    logic [DATA_W-1:0] palette_rgb565 [PAL_DEPTH];
    logic [LW_W-1:0]   surface_width;
    logic [MODE_W-1:0] pixel_fmt;
    texel_write_t      pending_writes [$];

    int          mismatch_count;
    int unsigned cycle_count;
    bit          steady_flow;

    tiled_texture_pixel_writer_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, what);
    endtask

    // Byte offset of a pixel inside the tiled surface, before wrap
    function automatic longint tile_base(input logic [POS_W-1:0] x,
                                         input logic [POS_W-1:0] y,
                                         input bit rgba8);
        longint w;
        longint row;
        w   = (surface_width > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(surface_width);
        row = rgba8 ? longint'(16) : longint'(8);
        return longint'(y >> 2) * row * w
             + longint'(x >> 2) * (rgba8 ? 64 : 32)
             + longint'({y[1:0], x[1:0]}) * 2;
    endfunction

    function automatic void push_write(input longint off,
                                       input logic [DATA_W-1:0] data,
                                       input logic last);
        texel_write_t w;
        longint       wrapped;
        wrapped  = off % TEX_BYTES;
        w.offset = wrapped[OFF_W-1:0];
        w.data   = data;
        w.last   = last;
        pending_writes.push_back(w);
    endfunction

    // Update palette or queue the writes that one accepted item causes
    function automatic void predict_texel_writes(input texel_item_t it);
        longint            base;
        logic [BYTE_W-1:0] p;
        logic [DATA_W-1:0] color;
        if (it.op == OP_PAL_WRITE)
        begin
            if (it.idx < PAL_DEPTH)
                palette_rgb565[it.idx] = {it.red[7:3], it.green[7:2], it.blue[7:3]};
            return;
        end
        if (pixel_fmt == MODE_PAL8 || pixel_fmt == MODE_RGB565)
        begin
            p = it.src[31:24];
            if (pixel_fmt == MODE_PAL8)
                color = (p < PAL_DEPTH) ? palette_rgb565[p] : '0;
            else
                color = it.src[31:16];
            push_write(tile_base(it.x, it.y, 1'b0), color, 1'b1);
            return;
        end
        base = tile_base(it.x, it.y, 1'b1);
        if (pixel_fmt == MODE_RGB)
        begin
            push_write(base, {8'hFF, it.src[31:24]}, 1'b0);
            push_write(base + HALF_OFFSET, it.src[23:8], 1'b1);
        end
        else
        begin
            push_write(base, it.src[31:16], 1'b0);
            push_write(base + HALF_OFFSET, it.src[15:0], 1'b1);
        end
    endfunction

    // Result checker: compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin : check_writes
        texel_write_t want;
        texel_write_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.offset = m_tdata[OFF_W-1:0];
            got.data   = m_tdata[OFF_W +: DATA_W];
            got.last   = m_tlast;
            if (pending_writes.size() == 0)
                log_mismatch($sformatf("unexpected write: offset %h data %h last %b",
                                       got.offset, got.data, got.last));
            else
            begin
                want = pending_writes.pop_front();
                if (got.offset !== want.offset || got.data !== want.data ||
                    got.last !== want.last)
                    log_mismatch($sformatf(
                        "write mismatch: offset %h data %h last %b, expected %h %h %b",
                        got.offset, got.data, got.last,
                        want.offset, want.data, want.last));
            end
        end
    end

    // Output side: random stall before each result transfer
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Send one item after a random gap; predicts at the transfer edge
    task automatic send_texel_item(input texel_item_t it);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        gap  = steady_flow ? 0 : $urandom_range(0, 8);
        word = '0;
        word[X_LSB +: POS_W]      = it.x;
        word[Y_LSB +: POS_W]      = it.y;
        word[SRC_LSB +: SRC_W]    = it.src;
        word[IDX_LSB +: BYTE_W]   = it.idx;
        word[RED_LSB +: BYTE_W]   = it.red;
        word[GREEN_LSB +: BYTE_W] = it.green;
        word[BLUE_LSB +: BYTE_W]  = it.blue;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= it.op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_texel_writes(it);
    endtask

    // Stop sending and let every expected write come out
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [LW_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_LINE_WIDTH)
            surface_width = value;
        else if (index == REG_PIXEL_MODE)
            pixel_fmt = value[MODE_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [LW_W-1:0] width, input logic [MODE_W-1:0] fmt);
        wait_idle();
        write_register(REG_LINE_WIDTH, width);
        write_register(REG_PIXEL_MODE, LW_W'(fmt));
    endtask

    function automatic texel_item_t pixel_item(input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y,
                                               input logic [SRC_W-1:0] src);
        texel_item_t it;
        it = '{OP_PIXEL, x, y, src, 8'h00, 8'h00, 8'h00, 8'h00};
        return it;
    endfunction

    function automatic texel_item_t palette_item(input logic [BYTE_W-1:0] idx,
                                                 input logic [BYTE_W-1:0] r,
                                                 input logic [BYTE_W-1:0] g,
                                                 input logic [BYTE_W-1:0] b);
        texel_item_t it;
        it = '{OP_PAL_WRITE, '0, '0, '0, idx, r, g, b};
        return it;
    endfunction

    // Coordinates lean toward the edges of the range
    function automatic logic [POS_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POS_MAX;
            default: return POS_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic texel_item_t random_item(input bit pixel);
        texel_item_t it;
        it.op    = pixel ? OP_PIXEL : OP_PAL_WRITE;
        it.x     = random_coord();
        it.y     = random_coord();
        it.src   = $urandom();
        it.idx   = BYTE_W'($urandom_range(0, 255));
        it.red   = BYTE_W'($urandom_range(0, 255));
        it.green = BYTE_W'($urandom_range(0, 255));
        it.blue  = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    // Reset settings: RGB565 pass-through at width 640
    task automatic test_reset_settings();
        send_texel_item(pixel_item('0, '0, 32'h0000_0000));
        send_texel_item(pixel_item(POS_MAX, POS_MAX, 32'hFFFF_FFFF));
        send_texel_item(palette_item(8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_texel_item(pixel_item(10'd5, 10'd6, 32'hA5C3_1234));
    endtask

    // Palette lookups, unwritten entries and write-then-read
    task automatic test_palette_lookup();
        set_config(LW_W'(640), MODE_PAL8);
        send_texel_item(pixel_item(10'd3, 10'd2, 32'h80FF_FFFF));
        send_texel_item(palette_item(8'hFF, 8'h08, 8'h04, 8'h08));
        send_texel_item(palette_item(8'h80, 8'hF7, 8'h03, 8'h7F));
        send_texel_item(pixel_item(10'd0, 10'd1, 32'h0012_3456));
        send_texel_item(pixel_item(10'd9, 10'd4, 32'hFF00_0000));
        send_texel_item(pixel_item(POS_MAX, 10'd0, 32'h80AB_CDEF));
        send_texel_item(palette_item(8'h03, 8'h5A, 8'hA5, 8'hC3));
        send_texel_item(pixel_item(10'd0, POS_MAX, 32'h03FF_FFFF));
    endtask

    // RGBA8 modes, wrap at the texture end, clamped and tiny widths
    task automatic test_rgba_layout();
        set_config(LW_W'(MAX_WIDTH), MODE_RGB);
        send_texel_item(pixel_item(POS_MAX, POS_MAX, 32'hFFFF_FFFF));
        send_texel_item(pixel_item('0, '0, 32'h1234_5678));
        set_config(LW_W'(MAX_WIDTH), MODE_ARGB);
        send_texel_item(pixel_item(POS_MAX, POS_MAX, 32'h8765_4321));
        send_texel_item(pixel_item('0, '0, 32'h0000_0000));
        set_config({LW_W{1'b1}}, MODE_ARGB);
        send_texel_item(pixel_item(10'd1022, 10'd1021, 32'hDEAD_BEEF));
        set_config(LW_W'(0), MODE_RGB);
        send_texel_item(pixel_item(10'd7, 10'd9, 32'hC0FF_EE11));
        set_config(LW_W'(4), MODE_PAL8);
        send_texel_item(pixel_item(10'd6, 10'd13, 32'hFF12_3456));
    endtask

    // Random items over several settings; about one in five is a palette write
    task automatic test_random_stream();
        logic [LW_W-1:0]   widths [PHASES];
        logic [MODE_W-1:0] fmts [PHASES];
        int                pixels;
        widths = '{LW_W'(640), LW_W'(4), LW_W'(1024), LW_W'(2047),
                   LW_W'(0), LW_W'(1025), LW_W'(1), LW_W'(0)};
        fmts   = '{MODE_PAL8, MODE_ARGB, MODE_RGB, MODE_RGB565,
                   MODE_RGB, MODE_PAL8, MODE_ARGB, MODE_RGB565};
        widths[PHASES-1] = LW_W'($urandom_range(0, 2047));
        fmts[PHASES-1]   = MODE_W'($urandom_range(0, 3));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_config(widths[ph], fmts[ph]);
            pixels = 0;
            while (pixels < PHASE_PIXELS)
            begin
                if (pixels % 50 == 0)
                    steady_flow = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                    send_texel_item(random_item(1'b0));
                else
                begin
                    send_texel_item(random_item(1'b1));
                    pixels++;
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin : run
        int drain_cycles;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_PAL_WRITE;
        cfg_valid      = 1'b0;
        cfg_index      = REG_LINE_WIDTH;
        cfg_data       = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady_flow    = 1'b0;
        surface_width  = LW_RESET;
        pixel_fmt      = MODE_RESET;
        foreach (palette_rgb565[i])
            palette_rgb565[i] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_settings();
        test_palette_lookup();
        test_rgba_layout();
        test_random_stream();

        // Drain: every expected write must arrive
        @(negedge clk);
        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_writes.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (IDLE_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
            log_mismatch($sformatf("%0d expected writes never arrived",
                                   pending_writes.size()));

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
